[src/swsp_pkg.sv]
// Package for the shell word splitter: result kinds, lexer modes, character
// codes and the result-group types shared by the lexer, the queue and the top.
// No dependencies.
package swsp_pkg;

    localparam int MAX_RESULTS = 4;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_WEND = 2'd1,
        KIND_LEND = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_P_ESC  = 3'd1,
        MODE_DOLLAR = 3'd2,
        MODE_SINGLE = 3'd3,
        MODE_DOUBLE = 3'd4,
        MODE_D_ESC  = 3'd5,
        MODE_EXPAND = 3'd6
    } mode_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       last;
    } entry_t;

    typedef struct packed {
        logic [2:0]                   count;
        entry_t [MAX_RESULTS-1:0]     ents;
    } group_t;

endpackage

[src/shell_word_splitter.sv]
// Shell word splitter top level: input register, lexer step and result queue.
// A byte waits in the input register until its whole group is pushed into the queue.
// Throughput: one byte per cycle while the queue has room for its whole group
// of up to four results; results leave at one per cycle while out_stall is low
// from a QUEUE_DEPTH entry queue, so the result side sets the sustained rate.
// Reset: asynchronous, active low; plain state, no word open, queue empty.
module shell_word_splitter #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    input  logic       line_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] char_out,
    output logic       run_last
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        char_reg;
    logic              last_reg;
    swsp_pkg::mode_t   mode_reg, mode_next;
    logic              word_open_reg, word_open_next;
    swsp_pkg::group_t  group;
    swsp_pkg::entry_t  out_entry;
    logic              push_ok;
    logic              advance;
    logic              in_xfer;

    // The held byte moves on once its whole group fits in the queue.
    assign advance  = in_valid_reg && push_ok;
    assign in_stall = in_valid_reg && !push_ok;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    swsp_lexer u_lexer (
        .mode_cur       (mode_reg),
        .word_open_cur  (word_open_reg),
        .char_in        (char_reg),
        .line_last      (last_reg),
        .group          (group),
        .mode_next      (mode_next),
        .word_open_next (word_open_next)
    );

    swsp_res_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_group (group),
        .push_en    (in_valid_reg),
        .push_ok    (push_ok),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_entry  (out_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mode_reg      <= swsp_pkg::MODE_PLAIN;
            word_open_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                mode_reg      <= mode_next;
                word_open_reg <= word_open_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            char_reg <= char_in;
            last_reg <= line_last;
        end
    end

    assign kind     = out_entry.kind;
    assign char_out = out_entry.ch;
    assign run_last = out_entry.last;

endmodule

[src/swsp_lexer.sv]
// Lexer step for the shell word splitter: from the current mode, the word
// state and one byte, forms the group of up to four results and the next state.
// Depends on swsp_pkg.
module swsp_lexer (
    input  swsp_pkg::mode_t  mode_cur,
    input  logic             word_open_cur,
    input  logic [7:0]       char_in,
    input  logic             line_last,
    output swsp_pkg::group_t group,
    output swsp_pkg::mode_t  mode_next,
    output logic             word_open_next
);

    always_comb
    begin
        swsp_pkg::mode_t  mode;
        logic             wo;
        logic [2:0]       n;
        logic             do_plain;
        swsp_pkg::entry_t [swsp_pkg::MAX_RESULTS-1:0] ents;

        mode     = mode_cur;
        wo       = word_open_cur;
        n        = 3'd0;
        do_plain = 1'b0;
        ents     = '0;

        unique case (mode_cur)
            swsp_pkg::MODE_P_ESC:
            begin
                ents[n[1:0]].kind = swsp_pkg::KIND_CHAR;
                ents[n[1:0]].ch   = char_in;
                n    = n + 3'd1;
                wo   = 1'b1;
                mode = swsp_pkg::MODE_PLAIN;
            end
            swsp_pkg::MODE_DOLLAR:
            begin
                ents[n[1:0]].kind = swsp_pkg::KIND_CHAR;
                ents[n[1:0]].ch   = swsp_pkg::CH_DOLLAR;
                n  = n + 3'd1;
                wo = 1'b1;
                if (char_in == swsp_pkg::CH_LPAREN)
                begin
                    ents[n[1:0]].kind = swsp_pkg::KIND_CHAR;
                    ents[n[1:0]].ch   = char_in;
                    n    = n + 3'd1;
                    mode = swsp_pkg::MODE_EXPAND;
                end
                else
                begin
                    mode     = swsp_pkg::MODE_PLAIN;
                    do_plain = 1'b1;
                end
            end
            swsp_pkg::MODE_SINGLE:
            begin
                if (char_in == swsp_pkg::CH_SQUOTE)
                begin
                    mode = swsp_pkg::MODE_PLAIN;
                end
                else
                begin
                    ents[n[1:0]].kind = swsp_pkg::KIND_CHAR;
                    ents[n[1:0]].ch   = char_in;
                    n  = n + 3'd1;
                    wo = 1'b1;
                end
            end
            swsp_pkg::MODE_DOUBLE:
            begin
                if (char_in == swsp_pkg::CH_DQUOTE)
                begin
                    mode = swsp_pkg::MODE_PLAIN;
                end
                else if (char_in == swsp_pkg::CH_BSLASH)
                begin
                    mode = swsp_pkg::MODE_D_ESC;
                end
                else
                begin
                    ents[n[1:0]].kind = swsp_pkg::KIND_CHAR;
                    ents[n[1:0]].ch   = char_in;
                    n  = n + 3'd1;
                    wo = 1'b1;
                end
            end
            swsp_pkg::MODE_D_ESC:
            begin
                // Only a quote or a backslash is really escaped; otherwise
                // the backslash stays in the word.
                if (char_in != swsp_pkg::CH_DQUOTE && char_in != swsp_pkg::CH_BSLASH)
                begin
                    ents[n[1:0]].kind = swsp_pkg::KIND_CHAR;
                    ents[n[1:0]].ch   = swsp_pkg::CH_BSLASH;
                    n = n + 3'd1;
                end
                ents[n[1:0]].kind = swsp_pkg::KIND_CHAR;
                ents[n[1:0]].ch   = char_in;
                n    = n + 3'd1;
                wo   = 1'b1;
                mode = swsp_pkg::MODE_DOUBLE;
            end
            swsp_pkg::MODE_EXPAND:
            begin
                ents[n[1:0]].kind = swsp_pkg::KIND_CHAR;
                ents[n[1:0]].ch   = char_in;
                n  = n + 3'd1;
                wo = 1'b1;
                if (char_in == swsp_pkg::CH_RPAREN)
                begin
                    mode = swsp_pkg::MODE_PLAIN;
                end
            end
            default:
            begin
                mode     = swsp_pkg::MODE_PLAIN;
                do_plain = 1'b1;
            end
        endcase

        if (do_plain)
        begin
            if (char_in == swsp_pkg::CH_SPACE || char_in == swsp_pkg::CH_TAB)
            begin
                if (wo)
                begin
                    ents[n[1:0]].kind = swsp_pkg::KIND_WEND;
                    n  = n + 3'd1;
                    wo = 1'b0;
                end
            end
            else if (char_in == swsp_pkg::CH_SQUOTE)
            begin
                mode = swsp_pkg::MODE_SINGLE;
            end
            else if (char_in == swsp_pkg::CH_DQUOTE)
            begin
                mode = swsp_pkg::MODE_DOUBLE;
            end
            else if (char_in == swsp_pkg::CH_DOLLAR)
            begin
                mode = swsp_pkg::MODE_DOLLAR;
            end
            else if (char_in == swsp_pkg::CH_BSLASH)
            begin
                mode = swsp_pkg::MODE_P_ESC;
            end
            else
            begin
                ents[n[1:0]].kind = swsp_pkg::KIND_CHAR;
                ents[n[1:0]].ch   = char_in;
                n  = n + 3'd1;
                wo = 1'b1;
            end
        end

        // At line end a pending dollar is kept, a pending backslash is dropped,
        // and an open word is closed before the end-of-line mark.
        if (line_last)
        begin
            if (mode == swsp_pkg::MODE_DOLLAR)
            begin
                ents[n[1:0]].kind = swsp_pkg::KIND_CHAR;
                ents[n[1:0]].ch   = swsp_pkg::CH_DOLLAR;
                n  = n + 3'd1;
                wo = 1'b1;
            end
            if (wo)
            begin
                ents[n[1:0]].kind = swsp_pkg::KIND_WEND;
                n = n + 3'd1;
            end
            ents[n[1:0]].kind = swsp_pkg::KIND_LEND;
            n    = n + 3'd1;
            mode = swsp_pkg::MODE_PLAIN;
            wo   = 1'b0;
        end

        for (int i = 0; i < swsp_pkg::MAX_RESULTS; i++)
        begin
            ents[i].last = (n != 3'd0) && (3'(i) == n - 3'd1);
        end

        group.count    = n;
        group.ents     = ents;
        mode_next      = mode;
        word_open_next = wo;
    end

endmodule

[src/swsp_res_queue.sv]
// Result queue for the shell word splitter: takes a whole group of up to four
// results in one cycle and hands them out one per transfer.
// Depends on swsp_pkg.
module swsp_res_queue #(
    parameter int DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  swsp_pkg::group_t push_group,
    input  logic             push_en,
    output logic             push_ok,
    output logic             out_valid,
    input  logic             out_stall,
    output swsp_pkg::entry_t out_entry
);

    // DEPTH must be at least MAX_RESULTS so that any group fits an empty queue.
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = PW + 3;

    swsp_pkg::entry_t mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             pop;
    logic             push;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                               input logic [2:0] ofs);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(ofs);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    assign push_ok   = (CW'(count_reg) + CW'(push_group.count)) <= CW'(DEPTH)
                       && ((CW+1)'(count_reg) + (CW+1)'(push_group.count))
                          <= (CW+1)'(DEPTH);
    assign push      = push_en && push_ok;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign out_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wrap_add(wr_ptr_reg, push_group.count);
            count_next  = count_next + CW'(push_group.count);
        end
        if (pop)
        begin
            rd_ptr_next = wrap_add(rd_ptr_reg, 3'd1);
            count_next  = count_next - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < swsp_pkg::MAX_RESULTS; i++)
        begin
            if (push && (3'(i) < push_group.count))
            begin
                mem_reg[wrap_add(wr_ptr_reg, 3'(i))] <= push_group.ents[i];
            end
        end
    end

endmodule
